/* rtl/core/thfd_pkg.sv */
// ============================================================================
// thfd_pkg
// Shared types and constants for the texel hole-fill dilation block.
// ============================================================================
package thfd_pkg;

  // Channel and accumulator widths.
  localparam int unsigned CH_W     = 24;  // unsigned 16.8 fixed point
  localparam int unsigned SUM_W    = 26;  // sum of up to four channels
  localparam int unsigned CNT_W    = 3;   // neighbor count, 0 to 4
  localparam int unsigned QUO_W    = 25;  // quotient of a sum by three

  // Frame geometry registers.
  localparam int unsigned FW_W     = 9;   // frame_width register
  localparam int unsigned FH_W     = 13;  // frame_height register
  localparam int unsigned CFG_W    = 13;  // widest register
  localparam int unsigned OROW_W   = 12;  // output row, below the height
  localparam logic [FW_W-1:0] FW_RESET     = 9'd256;
  localparam logic [FH_W-1:0] FH_RESET     = 13'd256;
  localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;

  // Register indexes of the configuration port.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Item kinds on the input channel.
  localparam logic OP_TEXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Division by three: floor(x * (2^28 - 1) / 3 / 2^28) is floor(x / 3)
  // or one less for any 26-bit x, so one compare and add corrects it.
  localparam int unsigned RECIP_W   = 27;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned MUL_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP3 = 27'h5555555;

  // One RGB texel.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } texel_t;

endpackage

/* rtl/core/texel_hole_fill_dilation_top.sv */
// ============================================================================
// texel_hole_fill_dilation_top
// Fills empty texels of a raster with the average of their valid
// four-neighbors, using a line store of two frame rows in one memory.
// ============================================================================
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  in       | in        | in_valid_i/in_stall_o | op_i, red/green/blue_in_i
//  out      | out       | out_valid_o/out_stall_i | red/green/blue_out_o,
//           |           |                       | was_filled_o, last_of_frame_o
//  cfg      | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//
// A texel of the first row is only stored, and a drain request that finds
// the frame still incomplete is taken with no result. A request that produces
// a result steps through four reads of the single-port line store (center,
// left, right, upper), a sum, the reciprocal multiply and the correction.
// The memory needs no clearing after reset; an unwritten entry may be read, but its data is never used.
// A held result stalls the block only when the next result is ready.

module texel_hole_fill_dilation_top #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [thfd_pkg::CH_W-1:0]   red_in_i,
  input  logic [thfd_pkg::CH_W-1:0]   green_in_i,
  input  logic [thfd_pkg::CH_W-1:0]   blue_in_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [thfd_pkg::CH_W-1:0]   red_out_o,
  output logic [thfd_pkg::CH_W-1:0]   green_out_o,
  output logic [thfd_pkg::CH_W-1:0]   blue_out_o,
  output logic                        was_filled_o,
  output logic                        last_of_frame_o,
  // Configuration port
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [thfd_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned DEPTH = 2 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEFT,
    S_RIGHT,
    S_UP,
    S_SUM,
    S_MUL,
    S_FIX
  } state_e;

  // Control state.
  state_e                          state_q, state_d;
  logic [thfd_pkg::FW_W-1:0]       width_q, width_d;
  logic [thfd_pkg::FH_W-1:0]       height_q, height_d;
  logic [thfd_pkg::FW_W-1:0]       in_col_q, in_col_d;
  logic [thfd_pkg::FH_W-1:0]       in_row_q, in_row_d;
  logic [AW-1:0]                   in_addr_q, in_addr_d;
  logic [thfd_pkg::FW_W-1:0]       out_col_q, out_col_d;
  logic [thfd_pkg::OROW_W-1:0]     out_row_q, out_row_d;
  logic [AW-1:0]                   out_addr_q, out_addr_d;
  logic                            out_valid_q, out_valid_d;
  thfd_pkg::texel_t                out_texel_q, out_texel_d;
  logic                            filled_q, filled_d;
  logic                            last_q, last_d;

  // Datapath registers.
  logic                            has_down_q;
  thfd_pkg::texel_t                down_q;
  thfd_pkg::texel_t                ctr_q;
  logic [2:0][thfd_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [thfd_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [2:0][thfd_pkg::PROD_W-1:0] prod_q;

  // Line store.
  thfd_pkg::texel_t                mem [DEPTH];
  thfd_pkg::texel_t                rd_q;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  thfd_pkg::texel_t                wr_data;

  // Effective geometry: zero counts as one, large values saturate.
  logic [thfd_pkg::FW_W-1:0]       eff_w;
  logic [thfd_pkg::FH_W-1:0]       eff_h;
  logic [AW-1:0]                   eff_w_a;

  always_comb begin
    if (width_q == '0) begin
      eff_w = thfd_pkg::FW_W'(1);
    end else if ({4'd0, width_q} > 13'(MAX_WIDTH)) begin
      eff_w = thfd_pkg::FW_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = thfd_pkg::FH_W'(1);
    end else if (height_q > thfd_pkg::HEIGHT_LIMIT) begin
      eff_h = thfd_pkg::HEIGHT_LIMIT;
    end else begin
      eff_h = height_q;
    end
    eff_w_a = AW'(eff_w);
  end

  // Request classification at the input.
  logic in_accept;
  logic frame_in;
  logic texel_req;
  logic emit_start;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign frame_in   = (in_row_q >= eff_h);
  assign texel_req  = in_accept && !frame_in && (op_i == thfd_pkg::OP_TEXEL);
  assign emit_start = in_accept && (frame_in || (texel_req && (in_row_q != '0)));

  // Neighbor addresses in the circular line store.
  logic [AW-1:0] addr_left;
  logic [AW-1:0] addr_right;
  logic [AW-1:0] addr_up;
  logic [AW:0]   up_diff;
  logic [AW-1:0] in_addr_next;
  logic [AW-1:0] out_addr_next;

  always_comb begin
    addr_left  = (out_addr_q == '0) ? AW'(DEPTH - 1) : out_addr_q - AW'(1);
    addr_right = (out_addr_q == AW'(DEPTH - 1)) ? '0 : out_addr_q + AW'(1);
    up_diff    = {1'b0, out_addr_q} - {1'b0, eff_w_a};
    addr_up    = up_diff[AW] ? AW'(up_diff + (AW + 1)'(DEPTH)) : up_diff[AW-1:0];
    in_addr_next  = (in_addr_q == AW'(DEPTH - 1)) ? '0 : in_addr_q + AW'(1);
    out_addr_next = addr_right;
  end

  // Output position flags.
  logic [thfd_pkg::FW_W-1:0] out_col_inc;
  logic                      out_last_col;
  logic                      out_last_row;
  logic [thfd_pkg::FW_W-1:0] in_col_inc;

  assign out_col_inc  = out_col_q + thfd_pkg::FW_W'(1);
  assign out_last_col = (out_col_inc == eff_w);
  assign out_last_row = (out_row_q == thfd_pkg::OROW_W'(eff_h - thfd_pkg::FH_W'(1)));
  assign in_col_inc   = in_col_q + thfd_pkg::FW_W'(1);

  // Read port sequencing: center at accept, then left, right and upper.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = out_addr_q;
    case (state_q)
      S_IDLE: begin
        rd_en   = emit_start;
        rd_addr = out_addr_q;
      end
      S_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = addr_left;
      end
      S_RIGHT: begin
        rd_en   = 1'b1;
        rd_addr = addr_right;
      end
      S_UP: begin
        rd_en   = 1'b1;
        rd_addr = addr_up;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = out_addr_q;
      end
    endcase
  end

  // Write port: first-row texels at accept, others after the upper read.
  always_comb begin
    if (state_q == S_IDLE) begin
      wr_en   = texel_req && (in_row_q == '0);
      wr_data = '{red: red_in_i, green: green_in_i, blue: blue_in_i};
    end else begin
      wr_en   = (state_q == S_SUM) && has_down_q;
      wr_data = down_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Neighbor accumulation as the read data arrives.
  logic rd_valid;
  logic add_nb;
  logic down_valid;

  assign rd_valid   = (rd_q != '0);
  assign down_valid = has_down_q && (down_q != '0);

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    add_nb = 1'b0;
    case (state_q)
      S_IDLE: begin
        sum_d = '0;
        cnt_d = '0;
      end
      S_RIGHT: add_nb = rd_valid && (out_col_q != '0);
      S_UP:    add_nb = rd_valid && !out_last_col;
      S_SUM:   add_nb = rd_valid && (out_row_q != '0);
      default: add_nb = 1'b0;
    endcase
    if (add_nb) begin
      sum_d[0] = sum_d[0] + thfd_pkg::SUM_W'(rd_q.red);
      sum_d[1] = sum_d[1] + thfd_pkg::SUM_W'(rd_q.green);
      sum_d[2] = sum_d[2] + thfd_pkg::SUM_W'(rd_q.blue);
      cnt_d    = cnt_d + thfd_pkg::CNT_W'(1);
    end
    // The lower neighbor is the texel that came with this request.
    if ((state_q == S_SUM) && down_valid) begin
      sum_d[0] = sum_d[0] + thfd_pkg::SUM_W'(down_q.red);
      sum_d[1] = sum_d[1] + thfd_pkg::SUM_W'(down_q.green);
      sum_d[2] = sum_d[2] + thfd_pkg::SUM_W'(down_q.blue);
      cnt_d    = cnt_d + thfd_pkg::CNT_W'(1);
    end
  end

  // Average of the neighbors; division by three uses the reciprocal and a correction.
  logic [2:0][thfd_pkg::CH_W-1:0] avg;
  thfd_pkg::texel_t               result;
  logic                           result_filled;

  always_comb begin
    logic [thfd_pkg::QUO_W-1:0] q0;
    logic [thfd_pkg::SUM_W-1:0] rem;
    logic [thfd_pkg::SUM_W-1:0] quo;
    q0  = '0;
    rem = '0;
    quo = '0;
    for (int c = 0; c < 3; c++) begin
      q0  = prod_q[c][thfd_pkg::MUL_SHIFT +: thfd_pkg::QUO_W];
      rem = sum_q[c] - (thfd_pkg::SUM_W'(q0) + thfd_pkg::SUM_W'({q0, 1'b0}));
      case (cnt_q)
        3'd1:    quo = sum_q[c];
        3'd2:    quo = sum_q[c] >> 1;
        3'd3:    quo = thfd_pkg::SUM_W'(q0) +
                       thfd_pkg::SUM_W'(rem >= thfd_pkg::SUM_W'(3));
        3'd4:    quo = sum_q[c] >> 2;
        default: quo = '0;
      endcase
      avg[c] = quo[thfd_pkg::CH_W-1:0];
    end
    if (ctr_q != '0) begin
      result        = ctr_q;
      result_filled = 1'b0;
    end else if (cnt_q == '0) begin
      result        = '0;
      result_filled = 1'b0;
    end else begin
      result        = '{red: avg[0], green: avg[1], blue: avg[2]};
      result_filled = 1'b1;
    end
  end

  // Next-state logic for the sequencer, counters and output register.
  logic out_free;
  logic out_take;

  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    in_addr_d   = in_addr_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_addr_d  = out_addr_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    out_texel_d = out_texel_q;
    filled_d    = filled_q;
    last_d      = last_q;

    // Advance the input position after a texel is stored.
    if (wr_en) begin
      in_addr_d = in_addr_next;
      if (in_col_inc == eff_w) begin
        in_col_d = '0;
        in_row_d = in_row_q + thfd_pkg::FH_W'(1);
      end else begin
        in_col_d = in_col_inc;
      end
    end

    case (state_q)
      S_IDLE:  if (emit_start) state_d = S_LEFT;
      S_LEFT:  state_d = S_RIGHT;
      S_RIGHT: state_d = S_UP;
      S_UP:    state_d = S_SUM;
      S_SUM:   state_d = S_MUL;
      S_MUL:   state_d = S_FIX;
      S_FIX: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_texel_d = result;
          filled_d    = result_filled;
          last_d      = out_last_col && out_last_row;
          if (out_last_col && out_last_row) begin
            // End of frame: every position returns to the origin.
            in_col_d   = '0;
            in_row_d   = '0;
            in_addr_d  = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            out_addr_d = '0;
          end else begin
            out_addr_d = out_addr_next;
            if (out_last_col) begin
              out_col_d = '0;
              out_row_d = out_row_q + thfd_pkg::OROW_W'(1);
            end else begin
              out_col_d = out_col_inc;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A register write restarts the frame; the store keeps its contents.
    if (cfg_we_i) begin
      if (cfg_index_i == thfd_pkg::CFG_FRAME_WIDTH) begin
        width_d = cfg_data_i[thfd_pkg::FW_W-1:0];
      end else begin
        height_d = cfg_data_i[thfd_pkg::FH_W-1:0];
      end
      in_col_d   = '0;
      in_row_d   = '0;
      in_addr_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_addr_d = '0;
    end
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= thfd_pkg::FW_RESET;
      height_q    <= thfd_pkg::FH_RESET;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_addr_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_addr_q  <= '0;
      out_valid_q <= 1'b0;
      out_texel_q <= '0;
      filled_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      in_addr_q   <= in_addr_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_addr_q  <= out_addr_d;
      out_valid_q <= out_valid_d;
      out_texel_q <= out_texel_d;
      filled_q    <= filled_d;
      last_q      <= last_d;
    end
  end

  // Datapath registers: request texel, center, sums and products.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      has_down_q <= texel_req;
      down_q     <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
    end
    if (state_q == S_LEFT) begin
      ctr_q <= rd_q;
    end
    sum_q <= sum_d;
    cnt_q <= cnt_d;
    if (state_q == S_MUL) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= thfd_pkg::PROD_W'(sum_q[c]) * thfd_pkg::PROD_W'(thfd_pkg::RECIP3);
      end
    end
  end

  // Output ports.
  assign out_valid_o     = out_valid_q;
  assign red_out_o       = out_texel_q.red;
  assign green_out_o     = out_texel_q.green;
  assign blue_out_o      = out_texel_q.blue;
  assign was_filled_o    = filled_q;
  assign last_of_frame_o = last_q;

endmodule
